/* rtl/core/bdel_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the bounded double-ended list unit.
package bdel_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT = 3'd2;
	localparam logic [2:0] MODE_POP_BACK = 3'd3;
	localparam logic [2:0] MODE_LIST = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_LIST
	} op_t;

	typedef struct packed {
		op_t op;
		logic signed [31:0] value;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_LIST
	} back_state_t;

endpackage

/* rtl/core/bdel_front.sv */
`timescale 1ns / 1ps
// Input stage that accepts items, decodes the mode and drops meaningless modes.
module bdel_front import bdel_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         mode,
	input  logic signed [31:0] value,
	output logic               cmd_valid_s1,
	output cmd_t               cmd_s1,
	input  logic               cmd_stall
);

	logic take;
	logic mode_ok;
	op_t  op_dec;

	assign in_stall = cmd_valid_s1 && cmd_stall;
	assign take = in_valid && !in_stall;

	always_comb begin
		mode_ok = 1'b1;
		op_dec = OP_LIST;
		case (mode)
			MODE_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
			MODE_PUSH_BACK:  op_dec = OP_PUSH_BACK;
			MODE_POP_FRONT:  op_dec = OP_POP_FRONT;
			MODE_POP_BACK:   op_dec = OP_POP_BACK;
			MODE_LIST:       op_dec = OP_LIST;
			default:         mode_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!cmd_valid_s1 || !cmd_stall) begin
			cmd_valid_s1 <= take && mode_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op <= op_dec;
			cmd_s1.value <= value;
		end
	end

endmodule

/* rtl/core/bdel_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the decode stage and the list engine.
module bdel_queue import bdel_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t out_cmd
);

	cmd_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign in_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_cmd = entries_q[rd_ptr_q];
	assign push = in_valid && !in_stall;
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

/* rtl/core/bdel_back.sv */
`timescale 1ns / 1ps
// List engine with the ring buffer storage, pointers and the result register.
module bdel_back import bdel_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  cmd_t               cmd,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] value_res,
	output logic               last
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic signed [31:0] mem [DEPTH];

	back_state_t        state_q;
	back_state_t        state_n;
	logic [IW-1:0]      fidx_q;
	logic [IW-1:0]      fidx_n;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_n;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      idx_n;
	logic [CW-1:0]      idx_inc;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic               last_q;
	logic signed [31:0] value_q;

	logic               adv;
	logic               load;
	logic               ld_list;
	logic [1:0]         ld_status;
	logic               ld_last;
	logic [IW-1:0]      rd_addr;
	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	logic               is_full;
	logic               is_empty;

	function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
						   input logic [IW-1:0] off);
		logic [IW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (IW + 1)'(DEPTH)) begin
			s = s - (IW + 1)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	assign adv = !out_valid_q || !out_stall;
	assign is_full = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign idx_inc = idx_q + CW'(1);
	assign cmd_stall = !((state_q == BK_IDLE) && adv);

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign value_res = value_q;
	assign last = last_q;

	always_comb begin
		state_n = state_q;
		fidx_n = fidx_q;
		count_n = count_q;
		idx_n = idx_q;
		load = 1'b0;
		ld_list = 1'b0;
		ld_status = ST_OK;
		ld_last = 1'b1;
		rd_addr = fidx_q;
		wr_en = 1'b0;
		wr_addr = fidx_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && adv) begin
					load = 1'b1;
					case (cmd.op)
						OP_PUSH_FRONT: begin
							if (is_full) begin
								ld_status = ST_FULL;
							end else begin
								fidx_n = (fidx_q == '0) ? IW'(DEPTH - 1) : fidx_q - IW'(1);
								wr_en = 1'b1;
								wr_addr = fidx_n;
								count_n = count_q + CW'(1);
							end
						end
						OP_PUSH_BACK: begin
							if (is_full) begin
								ld_status = ST_FULL;
							end else begin
								wr_en = 1'b1;
								wr_addr = ring_add(fidx_q, count_q[IW-1:0]);
								count_n = count_q + CW'(1);
							end
						end
						OP_POP_FRONT: begin
							if (is_empty) begin
								ld_status = ST_EMPTY;
							end else begin
								fidx_n = ring_add(fidx_q, IW'(1));
								count_n = count_q - CW'(1);
							end
						end
						OP_POP_BACK: begin
							if (is_empty) begin
								ld_status = ST_EMPTY;
							end else begin
								count_n = count_q - CW'(1);
							end
						end
						OP_LIST: begin
							if (is_empty) begin
								ld_status = ST_EMPTY;
							end else begin
								ld_list = 1'b1;
								rd_addr = fidx_q;
								ld_last = (count_q == CW'(1));
								if (!ld_last) begin
									state_n = BK_LIST;
									idx_n = CW'(1);
								end
							end
						end
						default: ld_status = ST_OK;
					endcase
				end
			end
			BK_LIST: begin
				if (adv) begin
					load = 1'b1;
					ld_list = 1'b1;
					rd_addr = ring_add(fidx_q, idx_q[IW-1:0]);
					ld_last = (idx_inc == count_q);
					idx_n = idx_inc;
					if (ld_last) begin
						state_n = BK_IDLE;
					end
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			fidx_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			fidx_q <= fidx_n;
			count_q <= count_n;
			idx_q <= idx_n;
			if (adv) begin
				out_valid_q <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= cmd.value;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= ld_status;
			last_q <= ld_last;
			value_q <= ld_list ? mem[rd_addr] : '0;
		end
	end

endmodule

/* rtl/core/bounded_double_ended_list_unit.sv */
`timescale 1ns / 1ps
// Top level of the bounded double-ended list unit.
// A push or pop gives its status through the decode, queue and result registers.
// A listing reads one element per unstalled cycle from the ring buffer, front first.
// Throughput is one push or pop per unstalled cycle; a listing blocks new commands.
// Reset clears the pointers, the entry count and all valid flags; storage is not cleared.
module bounded_double_ended_list_unit import bdel_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         mode,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] value_res,
	output logic               last
);

	logic cmd_valid_s1;
	cmd_t cmd_s1;
	logic front_stall;
	logic q_valid;
	cmd_t q_cmd;
	logic q_stall;

	bdel_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.value        (value),
		.cmd_valid_s1 (cmd_valid_s1),
		.cmd_s1       (cmd_s1),
		.cmd_stall    (front_stall)
	);

	bdel_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_valid_s1),
		.in_stall  (front_stall),
		.in_cmd    (cmd_s1),
		.out_valid (q_valid),
		.out_stall (q_stall),
		.out_cmd   (q_cmd)
	);

	bdel_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_stall (q_stall),
		.cmd       (q_cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.value_res (value_res),
		.last      (last)
	);

endmodule
